FILE: rtl/core/pmu_pkg.sv
`timescale 1ns / 1ps
package pmu_pkg;

	localparam int MAX_NODES   = 1024;
	localparam int MAX_DEGREE  = 8;
	localparam int EXP_DEPTH   = 256;
	localparam int MAX_STATES  = 256;

	localparam int NODE_W      = 10;
	localparam int SLOT_W      = 3;
	localparam int SPIN_W      = 8;
	localparam int WEIGHT_W    = 16;
	localparam int DEG_W       = 4;
	localparam int RAND_W      = 16;
	localparam int OP_W        = 3;
	localparam int DE_W        = 20;
	localparam int ACC_W       = 20;
	localparam int NCNT_W      = 11;
	localparam int QCNT_W      = 9;
	localparam int ITEMP_W     = 16;
	localparam int EXP_IDX_W   = 8;
	localparam int EXP_SHIFT   = 12;
	localparam int EXP_W       = 16;

	localparam int EDGE_W      = NODE_W + WEIGHT_W;
	localparam int EDGE_AW     = NODE_W + SLOT_W;
	localparam int EDGE_DEPTH  = MAX_NODES * MAX_DEGREE;
	localparam int X_W         = DE_W - 1 + ITEMP_W;

	localparam int DE_MAX      = (1 << (DE_W - 1)) - 1;
	localparam int DE_MIN      = -(1 << (DE_W - 1));

	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;
	localparam int REG_IDX_W   = 2;

	localparam logic [31:0] EXP_STEP = 32'd4034748382;

	localparam logic [OP_W-1:0] OP_WR_SPIN = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_EDGE = 3'd1;
	localparam logic [OP_W-1:0] OP_WR_DEG  = 3'd2;
	localparam logic [OP_W-1:0] OP_UPDATE  = 3'd3;
	localparam logic [OP_W-1:0] OP_RD_SPIN = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_STATE_COUNT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_TEMP    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_TEMP   = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]            op;
		logic [NODE_W-1:0]          node;
		logic [SLOT_W-1:0]          slot;
		logic [SPIN_W-1:0]          spin_value;
		logic [NODE_W-1:0]          neighbor;
		logic signed [WEIGHT_W-1:0] weight;
		logic [DEG_W-1:0]           degree;
		logic [RAND_W-1:0]          rand_node;
		logic [RAND_W-1:0]          rand_prop;
		logic [RAND_W-1:0]          rand_accept;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0]      node_out;
		logic [SPIN_W-1:0]      spin_out;
		logic                   accepted;
		logic signed [DE_W-1:0] delta_energy;
	} result_t;

	typedef struct packed {
		logic [NCNT_W-1:0]  node_count;
		logic [QCNT_W-1:0]  state_count;
		logic [ITEMP_W-1:0] inv_temp;
		logic               zero_temp;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic decode;
		logic node_rd;
		logic cur_load;
		logic walk_issue;
		logic sat_load;
		logic exp_load;
		logic acc_load;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_update;
		logic walk_more;
		logic pipe_busy;
		logic out_free;
	} ctrl_sts_t;

	typedef logic [EXP_W-1:0] exp_tab_t [EXP_DEPTH];

	// exp(-k/16) in q0.16, stepped in q0.32 with round half up
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		logic [95:0] e;
		logic [95:0] v;
		e = 96'd1 << 32;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			v = (e + 96'h8000) >> 16;
			t[k] = (v > 96'd65535) ? {EXP_W{1'b1}} : v[EXP_W-1:0];
			e = (e * 96'(EXP_STEP) + 96'h8000_0000) >> 32;
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: rtl/core/pmu_regs.sv
`timescale 1ns / 1ps
module pmu_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pmu_pkg::PADDR_W-1:0] paddr,
	input  logic [pmu_pkg::PDATA_W-1:0] pwdata,
	output logic [pmu_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output pmu_pkg::cfg_t               cfg
);
	import pmu_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_count  <= NCNT_W'(MAX_NODES);
			cfg_q.state_count <= QCNT_W'(2);
			cfg_q.inv_temp    <= ITEMP_W'(256);
			cfg_q.zero_temp   <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_NODE_COUNT:  cfg_q.node_count  <= pwdata[NCNT_W-1:0];
				REG_STATE_COUNT: cfg_q.state_count <= pwdata[QCNT_W-1:0];
				REG_INV_TEMP:    cfg_q.inv_temp    <= pwdata[ITEMP_W-1:0];
				REG_ZERO_TEMP:   cfg_q.zero_temp   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NODE_COUNT:  prdata = PDATA_W'(cfg_q.node_count);
			REG_STATE_COUNT: prdata = PDATA_W'(cfg_q.state_count);
			REG_INV_TEMP:    prdata = PDATA_W'(cfg_q.inv_temp);
			REG_ZERO_TEMP:   prdata = PDATA_W'(cfg_q.zero_temp);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/pmu_ctrl.sv
`timescale 1ns / 1ps
module pmu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  pmu_pkg::ctrl_sts_t sts,
	output pmu_pkg::ctrl_cmd_t cmd
);
	import pmu_pkg::*;

	typedef enum logic [10:0] {
		S_CLEAR  = 11'b000_0000_0001,
		S_IDLE   = 11'b000_0000_0010,
		S_DECODE = 11'b000_0000_0100,
		S_NODE   = 11'b000_0000_1000,
		S_CUR    = 11'b000_0001_0000,
		S_WALK   = 11'b000_0010_0000,
		S_DRAIN  = 11'b000_0100_0000,
		S_SAT    = 11'b000_1000_0000,
		S_EXP    = 11'b001_0000_0000,
		S_ACC    = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR:  if (sts.clear_last) state_nxt = S_IDLE;
			S_IDLE:   if (item_valid) state_nxt = S_DECODE;
			S_DECODE: state_nxt = sts.is_update ? S_NODE : S_OUT;
			S_NODE:   state_nxt = S_CUR;
			S_CUR:    state_nxt = S_WALK;
			S_WALK:   if (!sts.walk_more) state_nxt = S_DRAIN;
			S_DRAIN:  if (!sts.pipe_busy) state_nxt = S_SAT;
			S_SAT:    state_nxt = S_EXP;
			S_EXP:    state_nxt = S_ACC;
			S_ACC:    state_nxt = S_OUT;
			S_OUT:    if (sts.out_free) state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	assign item_stall     = (state_q != S_IDLE);

	assign cmd.clear      = (state_q == S_CLEAR);
	assign cmd.capture    = (state_q == S_IDLE) && item_valid;
	assign cmd.decode     = (state_q == S_DECODE);
	assign cmd.node_rd    = (state_q == S_NODE);
	assign cmd.cur_load   = (state_q == S_CUR);
	assign cmd.walk_issue = (state_q == S_WALK) && sts.walk_more;
	assign cmd.sat_load   = (state_q == S_SAT);
	assign cmd.exp_load   = (state_q == S_EXP);
	assign cmd.acc_load   = (state_q == S_ACC);
	assign cmd.out_load   = (state_q == S_OUT) && sts.out_free;

endmodule

FILE: rtl/core/pmu_dp.sv
`timescale 1ns / 1ps
module pmu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pmu_pkg::item_t     item,
	input  pmu_pkg::cfg_t      cfg,
	input  pmu_pkg::ctrl_cmd_t cmd,
	output pmu_pkg::ctrl_sts_t sts,
	output logic               result_valid,
	input  logic               result_stall,
	output pmu_pkg::result_t   result
);
	import pmu_pkg::*;

	logic [SPIN_W-1:0] spin_mem [MAX_NODES];
	logic [DEG_W-1:0]  deg_mem  [MAX_NODES];
	logic [EDGE_W-1:0] edge_mem [EDGE_DEPTH];

	item_t                      item_q;
	logic [SPIN_W-1:0]          spin_rd_q;
	logic [DEG_W-1:0]           deg_rd_q;
	logic [EDGE_W-1:0]          edge_rd_q;
	logic [NODE_W-1:0]          clr_q;

	logic [NODE_W-1:0]          nd_q;
	logic [SPIN_W-1:0]          pbase_q;
	logic [SPIN_W-1:0]          cur_q;
	logic [SPIN_W-1:0]          prop_q;
	logic [DEG_W-1:0]           deg_q;
	logic [DEG_W-1:0]           k_q;
	logic                       edge_vld_s1;
	logic                       hit_s2;
	logic signed [WEIGHT_W-1:0] w_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [DE_W-1:0]     de_q;
	logic [X_W-1:0]             x_q;
	logic                       accept_q;
	result_t                    result_q;
	logic                       result_valid_q;

	logic [NCNT_W-1:0]          n_eff;
	logic [QCNT_W-1:0]          q_eff;
	logic [QCNT_W-1:0]          qm1;
	logic [RAND_W+NCNT_W-1:0]   node_prod;
	logic [RAND_W+SPIN_W-1:0]   prop_prod;
	logic                       is_upd;

	logic                       spin_we;
	logic [NODE_W-1:0]          spin_wa;
	logic [SPIN_W-1:0]          spin_wd;
	logic                       spin_re;
	logic [NODE_W-1:0]          spin_ra;
	logic                       deg_we;
	logic [NODE_W-1:0]          deg_wa;
	logic [DEG_W-1:0]           deg_wd;
	logic                       edge_we;

	logic [NODE_W-1:0]          edge_nb;
	logic signed [WEIGHT_W-1:0] edge_w;
	logic signed [ACC_W-1:0]    w_ext;
	logic signed [ACC_W-1:0]    term;
	logic signed [31:0]         acc32;
	logic signed [DE_W-1:0]     de_sat;
	logic [X_W-EXP_SHIFT-1:0]   x_hi;
	logic [EXP_IDX_W-1:0]       exp_idx;
	logic                       de_nonpos;
	result_t                    res_nxt;

	assign is_upd = (item_q.op == OP_UPDATE);

	// clamp configuration to the legal ranges
	always_comb begin
		if (cfg.node_count == '0) begin
			n_eff = NCNT_W'(1);
		end else if (cfg.node_count > NCNT_W'(MAX_NODES)) begin
			n_eff = NCNT_W'(MAX_NODES);
		end else begin
			n_eff = cfg.node_count;
		end
		if (cfg.state_count < QCNT_W'(2)) begin
			q_eff = QCNT_W'(2);
		end else if (cfg.state_count > QCNT_W'(MAX_STATES)) begin
			q_eff = QCNT_W'(MAX_STATES);
		end else begin
			q_eff = cfg.state_count;
		end
	end

	assign qm1       = q_eff - QCNT_W'(1);
	assign node_prod = (RAND_W+NCNT_W)'(item_q.rand_node) * (RAND_W+NCNT_W)'(n_eff);
	assign prop_prod = (RAND_W+SPIN_W)'(item_q.rand_prop) * (RAND_W+SPIN_W)'(qm1[SPIN_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.decode) begin
			nd_q    <= node_prod[RAND_W +: NODE_W];
			pbase_q <= prop_prod[RAND_W +: SPIN_W];
		end
	end

	// spin memory
	assign spin_we = (cmd.decode && item_q.op == OP_WR_SPIN) ||
	                 (cmd.out_load && is_upd && accept_q);
	assign spin_wa = cmd.decode ? item_q.node : nd_q;
	assign spin_wd = cmd.decode ? item_q.spin_value : prop_q;
	assign spin_re = edge_vld_s1 || cmd.node_rd ||
	                 (cmd.decode && item_q.op == OP_RD_SPIN);
	assign spin_ra = edge_vld_s1 ? edge_nb : (cmd.node_rd ? nd_q : item_q.node);

	always_ff @(posedge clk) begin
		if (spin_we) begin
			spin_mem[spin_wa] <= spin_wd;
		end
		if (spin_re) begin
			spin_rd_q <= spin_mem[spin_ra];
		end
	end

	// degree memory, swept to zero after reset
	assign deg_we = cmd.clear || (cmd.decode && item_q.op == OP_WR_DEG);
	assign deg_wa = cmd.clear ? clr_q : item_q.node;
	assign deg_wd = cmd.clear ? '0 : item_q.degree;

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_wa] <= deg_wd;
		end
		if (cmd.node_rd) begin
			deg_rd_q <= deg_mem[nd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + NODE_W'(1);
		end
	end

	// edge memory: neighbor and weight per node and slot
	assign edge_we = cmd.decode && item_q.op == OP_WR_EDGE;
	assign edge_nb = edge_rd_q[EDGE_W-1 -: NODE_W];
	assign edge_w  = edge_rd_q[WEIGHT_W-1:0];

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[{item_q.node, item_q.slot}] <= {item_q.neighbor, item_q.weight};
		end
		if (cmd.walk_issue) begin
			edge_rd_q <= edge_mem[{nd_q, k_q[SLOT_W-1:0]}];
		end
	end

	// neighbor walk: edge read, spin read, accumulate
	assign w_ext = ACC_W'(w_s2);
	always_comb begin
		if (spin_rd_q == cur_q) begin
			term = w_ext;
		end else if (spin_rd_q == prop_q) begin
			term = -w_ext;
		end else begin
			term = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_vld_s1 <= 1'b0;
			hit_s2      <= 1'b0;
		end else begin
			edge_vld_s1 <= cmd.walk_issue;
			hit_s2      <= edge_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_vld_s1) begin
			w_s2 <= edge_w;
		end
		if (cmd.cur_load) begin
			cur_q   <= spin_rd_q;
			deg_q   <= (deg_rd_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_rd_q;
			prop_q  <= (pbase_q >= spin_rd_q) ? pbase_q + SPIN_W'(1) : pbase_q;
			k_q     <= '0;
			acc_q   <= '0;
		end else begin
			if (cmd.walk_issue) begin
				k_q <= k_q + DEG_W'(1);
			end
			if (hit_s2) begin
				acc_q <= acc_q + term;
			end
		end
	end

	// saturation, exponent index, acceptance
	assign acc32 = 32'(acc_q);
	always_comb begin
		if (acc32 > DE_MAX) begin
			de_sat = DE_W'(DE_MAX);
		end else if (acc32 < DE_MIN) begin
			de_sat = DE_W'(DE_MIN);
		end else begin
			de_sat = DE_W'(acc32);
		end
	end

	assign x_hi      = x_q[X_W-1:EXP_SHIFT];
	assign exp_idx   = (x_hi > (X_W-EXP_SHIFT)'(EXP_DEPTH-1)) ?
	                   EXP_IDX_W'(EXP_DEPTH-1) : x_hi[EXP_IDX_W-1:0];
	assign de_nonpos = de_q[DE_W-1] || (de_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.sat_load) begin
			de_q <= de_sat;
		end
		if (cmd.exp_load) begin
			x_q <= X_W'(de_q[DE_W-2:0]) * X_W'(cfg.inv_temp);
		end
		if (cmd.acc_load) begin
			accept_q <= de_nonpos ||
			            (!cfg.zero_temp && item_q.rand_accept < EXP_TAB[exp_idx]);
		end
	end

	// result
	always_comb begin
		res_nxt.node_out     = item_q.node;
		res_nxt.spin_out     = '0;
		res_nxt.accepted     = 1'b0;
		res_nxt.delta_energy = '0;
		case (item_q.op)
			OP_WR_SPIN: res_nxt.spin_out = item_q.spin_value;
			OP_RD_SPIN: res_nxt.spin_out = spin_rd_q;
			OP_UPDATE: begin
				res_nxt.node_out     = nd_q;
				res_nxt.spin_out     = accept_q ? prop_q : cur_q;
				res_nxt.accepted     = accept_q;
				res_nxt.delta_energy = de_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign sts.clear_last = (clr_q == NODE_W'(MAX_NODES-1));
	assign sts.is_update  = is_upd;
	assign sts.walk_more  = (k_q < deg_q);
	assign sts.pipe_busy  = edge_vld_s1 || hit_s2;
	assign sts.out_free   = !result_valid_q || !result_stall;

`ifndef SYNTHESIS
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_issue |-> (k_q < deg_q) && (deg_q <= DEG_W'(MAX_DEGREE)))
		else $error("neighbor walk past degree");
	a_prop_differs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_issue |-> prop_q != cur_q)
		else $error("proposal equals current spin");
	a_spin_port: assert property (@(posedge clk) disable iff (!arst_n)
		edge_vld_s1 |-> !cmd.node_rd && !(cmd.decode && item_q.op == OP_RD_SPIN))
		else $error("spin read port conflict");
	a_downhill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && is_upd && de_nonpos |=> result.accepted)
		else $error("non-positive energy change rejected");
`endif

endmodule

FILE: rtl/core/potts_metropolis_update_top.sv
`timescale 1ns / 1ps
// channel   direction  valid / stall              payload
// item      in         item_valid / item_stall    item   (pmu_pkg::item_t)
// result    out        result_valid / result_stall result (pmu_pkg::result_t)
// config    in         psel, penable, pwrite      paddr, pwdata, prdata
//
// writes and spin reads go through decode and output, the next item is taken after output
// an update adds node read, current spin load, neighbor walk, drain, saturate, exp and accept
// the walk makes one edge memory and one spin memory read per neighbor, each one read port
// after reset all 1024 degree memory entries are swept to zero, item_stall high
// the result register holds under result_stall; the next item is taken meanwhile
module potts_metropolis_update_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  pmu_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output pmu_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pmu_pkg::PADDR_W-1:0] paddr,
	input  logic [pmu_pkg::PDATA_W-1:0] pwdata,
	output logic [pmu_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import pmu_pkg::*;

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	pmu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pmu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	pmu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: verif/potts_metropolis_update_checker.sv
`timescale 1ns / 1ps
module potts_metropolis_update_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  pmu_pkg::item_t     item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  pmu_pkg::result_t   result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [pmu_pkg::PADDR_W-1:0] paddr,
	input  logic [pmu_pkg::PDATA_W-1:0] pwdata,
	output int                 fail_count,
	output int                 pending
);
	import pmu_pkg::*;

	cfg_t                  cfg;
	logic [SPIN_W-1:0]     spin_mem [MAX_NODES];
	logic [DEG_W-1:0]      deg_mem [MAX_NODES];
	logic [NODE_W-1:0]     nb_mem [EDGE_DEPTH];
	logic signed [WEIGHT_W-1:0] w_mem [EDGE_DEPTH];
	logic [EXP_W-1:0]      exp_lut [EXP_DEPTH];
	result_t               due_outcomes [$];

	// exp(-k/16) in q0.16, stepped in q0.32 with round half up
	initial begin
		logic [95:0] acc;
		logic [95:0] rounded;
		acc = 96'd1 << 32;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			rounded = (acc + 96'h8000) >> 16;
			exp_lut[k] = (rounded > 96'd65535) ? '1 : rounded[EXP_W-1:0];
			acc = (acc * {64'd0, EXP_STEP} + 96'h8000_0000) >> 32;
		end
	end

	function automatic result_t metropolis_step(item_t it);
		result_t r;
		int unsigned n, q, nd, cur, prop, nn, j, addr, idx;
		int de;
		longint unsigned scaled;
		logic take;
		r = '0;
		r.node_out = it.node;
		case (it.op)
			OP_WR_SPIN: begin
				spin_mem[it.node] = it.spin_value;
				r.spin_out = it.spin_value;
			end
			OP_WR_EDGE: begin
				nb_mem[{it.node, it.slot}] = it.neighbor;
				w_mem[{it.node, it.slot}] = it.weight;
			end
			OP_WR_DEG: begin
				deg_mem[it.node] = it.degree;
			end
			OP_RD_SPIN: begin
				r.spin_out = spin_mem[it.node];
			end
			OP_UPDATE: begin
				n = cfg.node_count;
				if (n < 1) n = 1;
				if (n > MAX_NODES) n = MAX_NODES;
				q = cfg.state_count;
				if (q < 2) q = 2;
				if (q > MAX_STATES) q = MAX_STATES;
				nd = (it.rand_node * n) >> 16;
				if (nd >= n) nd = n - 1;
				cur = spin_mem[nd];
				prop = (it.rand_prop * (q - 1)) >> 16;
				if (prop >= cur) prop++;
				nn = deg_mem[nd];
				if (nn > MAX_DEGREE) nn = MAX_DEGREE;
				de = 0;
				for (int k = 0; k < nn; k++) begin
					addr = nd * MAX_DEGREE + k;
					j = nb_mem[addr];
					if (j < MAX_NODES) begin
						if (spin_mem[j] == cur) de = de + w_mem[addr];
						if (spin_mem[j] == prop) de = de - w_mem[addr];
					end
				end
				if (de > DE_MAX) de = DE_MAX;
				if (de < DE_MIN) de = DE_MIN;
				take = (de <= 0);
				if (!take && !cfg.zero_temp) begin
					scaled = longint'(de) * cfg.inv_temp;
					idx = 32'(scaled >> EXP_SHIFT);
					if (idx > EXP_DEPTH - 1) idx = EXP_DEPTH - 1;
					take = it.rand_accept < exp_lut[idx];
				end
				if (take) spin_mem[nd] = prop[SPIN_W-1:0];
				r.node_out = nd[NODE_W-1:0];
				r.spin_out = spin_mem[nd];
				r.accepted = take;
				r.delta_energy = de[DE_W-1:0];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic flag(input string field, input int want, input int got);
		fail_count++;
		$display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cfg.node_count = 11'd1024;
			cfg.state_count = 9'd2;
			cfg.inv_temp = 16'd256;
			cfg.zero_temp = 1'b0;
			for (int i = 0; i < MAX_NODES; i++) begin
				spin_mem[i] = '0;
				deg_mem[i] = '0;
			end
			for (int i = 0; i < EDGE_DEPTH; i++) begin
				nb_mem[i] = '0;
				w_mem[i] = '0;
			end
			due_outcomes.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (due_outcomes.size() == 0) begin
					fail_count++;
					$display("%0t unexpected transfer: expected none, actual node_out %0d spin_out %0d",
						$time, result.node_out, result.spin_out);
				end else begin
					want = due_outcomes.pop_front();
					if (result.node_out != want.node_out)
						flag("node_out", want.node_out, result.node_out);
					if (result.spin_out != want.spin_out)
						flag("spin_out", want.spin_out, result.spin_out);
					if (result.accepted !== want.accepted)
						flag("accepted", want.accepted, result.accepted);
					if (result.delta_energy != want.delta_energy)
						flag("delta_energy", want.delta_energy, result.delta_energy);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_NODE_COUNT:  cfg.node_count = pwdata[NCNT_W-1:0];
					REG_STATE_COUNT: cfg.state_count = pwdata[QCNT_W-1:0];
					REG_INV_TEMP:    cfg.inv_temp = pwdata[ITEMP_W-1:0];
					REG_ZERO_TEMP:   cfg.zero_temp = pwdata[0];
					default: begin
					end
				endcase
			end
			if (item_valid && !item_stall) due_outcomes.push_back(metropolis_step(item));
			pending = due_outcomes.size();
		end
	end
endmodule

FILE: verif/potts_metropolis_update_top_tb.sv
`timescale 1ns / 1ps
module potts_metropolis_update_top_tb;
	import pmu_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 108;
	localparam int CALM_ITEMS = 40;

	localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	item_t              item;
	logic               result_valid;
	logic               result_stall;
	result_t            result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 fail_count;
	int                 pending;
	int                 idle_cycles = 0;
	int                 n_eff = MAX_NODES;
	int                 q_eff = 2;
	logic               no_idle = 1'b0;
	logic [MAX_DEGREE-1:0] edge_known [MAX_NODES];

	int unsigned phase_nc [PHASES] = '{16, 0, 2047, 1024, 1, 64, 8};
	int unsigned phase_qc [PHASES] = '{4, 2, 256, 511, 1, 3, 0};
	int unsigned phase_it [PHASES] = '{256, 0, 65535, 1, 4096, 37, 128};
	int unsigned phase_zt [PHASES] = '{0, 0, 0, 1, 0, 0, 1};

	potts_metropolis_update_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	potts_metropolis_update_checker spin_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 15);
	endfunction

	// result side: random stall before each transfer
	initial begin
		int hold;
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(negedge clk); while (!result_valid);
			@(posedge clk);
		end
	end

	function automatic int filled_slots(int n);
		int f;
		f = 0;
		while (f < MAX_DEGREE && edge_known[n][f]) f++;
		return f;
	endfunction

	task automatic transfer_item(input item_t it);
		int gap;
		gap = draw_wait();
		if (it.op == OP_WR_EDGE) edge_known[it.node][it.slot] = 1'b1;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(negedge clk); while (item_stall);
		@(posedge clk);
	endtask

	task automatic put(input logic [OP_W-1:0] op, input int node, slot, spin, nb, w, deg,
		rn, rp, ra);
		item_t it;
		it.op = op;
		it.node = NODE_W'(node);
		it.slot = SLOT_W'(slot);
		it.spin_value = SPIN_W'(spin);
		it.neighbor = NODE_W'(nb);
		it.weight = WEIGHT_W'(w);
		it.degree = DEG_W'(deg);
		it.rand_node = RAND_W'(rn);
		it.rand_prop = RAND_W'(rp);
		it.rand_accept = RAND_W'(ra);
		transfer_item(it);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int unsigned nc, qc, itemp, zt);
		write_reg(REG_NODE_COUNT, nc);
		write_reg(REG_STATE_COUNT, qc);
		write_reg(REG_INV_TEMP, itemp);
		write_reg(REG_ZERO_TEMP, zt);
		n_eff = (nc == 0) ? 1 : (nc > MAX_NODES) ? MAX_NODES : nc;
		q_eff = (qc < 2) ? 2 : (qc > MAX_STATES) ? MAX_STATES : qc;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (24) @(posedge clk);
	endtask

	function automatic item_t random_op_item();
		item_t it;
		logic [127:0] noise;
		int pick, tgt, f;
		noise = {$urandom, $urandom, $urandom, $urandom};
		it = noise[$bits(item_t)-1:0];
		pick = $urandom_range(0, 99);
		tgt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_NODES - 1)
			: $urandom_range(0, n_eff - 1);
		if (pick < 40) begin
			it.op = OP_UPDATE;
			if ($urandom_range(0, 9) == 0) it.rand_node = $urandom_range(0, 1) ? '1 : '0;
			if ($urandom_range(0, 9) == 0) it.rand_accept = $urandom_range(0, 1) ? '1 : '0;
		end else if (pick < 60) begin
			it.op = OP_WR_EDGE;
			it.node = NODE_W'(tgt);
			f = filled_slots(tgt);
			if (f < MAX_DEGREE && $urandom_range(0, 9) < 7) it.slot = SLOT_W'(f);
			case ($urandom_range(0, 9))
				0: it.neighbor = NODE_W'(tgt);
				1, 2: begin
				end
				default: it.neighbor = NODE_W'($urandom_range(0, n_eff - 1));
			endcase
			if ($urandom_range(0, 1)) it.weight = WEIGHT_W'($urandom_range(0, 1023) - 512);
		end else if (pick < 70) begin
			it.op = OP_WR_DEG;
			it.node = NODE_W'(tgt);
			f = filled_slots(tgt);
			if (f < MAX_DEGREE && it.degree > f) it.degree = DEG_W'(f);
		end else if (pick < 82) begin
			it.op = OP_WR_SPIN;
			it.node = NODE_W'(tgt);
			if ($urandom_range(0, 4) != 0) it.spin_value = SPIN_W'($urandom_range(0, q_eff - 1));
		end else if (pick < 92) begin
			it.op = OP_RD_SPIN;
		end else begin
			it.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		end
		return it;
	endfunction

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < MAX_NODES; i++) edge_known[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small graph around nodes 0..2 plus the top node
		set_config(3, 4, 256, 0);
		put(OP_WR_SPIN, 0, 7, 0, 1023, -1, 15, 65535, 65535, 65535);
		put(OP_WR_SPIN, 1, 0, 255, 0, 0, 0, 0, 0, 0);
		put(OP_WR_SPIN, 2, 3, 3, 5, 77, 2, 100, 200, 300);
		put(OP_WR_SPIN, 1023, 1, 128, 512, 4, 8, 1, 2, 3);
		put(OP_WR_EDGE, 2, 0, 9, 1, -32768, 0, 0, 0, 0);
		put(OP_WR_EDGE, 2, 1, 9, 2, 32767, 0, 0, 0, 0);
		put(OP_WR_EDGE, 2, 2, 9, 1023, 256, 0, 0, 0, 0);
		put(OP_WR_EDGE, 2, 3, 9, 0, -1, 0, 0, 0, 0);
		put(OP_WR_EDGE, 2, 4, 9, 0, 1, 0, 0, 0, 0);
		put(OP_WR_EDGE, 2, 5, 9, 1, 256, 0, 0, 0, 0);
		put(OP_WR_EDGE, 2, 6, 9, 2, -300, 0, 0, 0, 0);
		put(OP_WR_EDGE, 2, 7, 9, 1023, 32767, 0, 0, 0, 0);
		put(OP_WR_DEG, 2, 5, 17, 33, 99, 15, 11, 22, 33);
		put(OP_WR_DEG, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
		put(OP_RD_SPIN, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
		put(OP_RD_SPIN, 1, 7, 255, 1023, -1, 15, 65535, 65535, 65535);
		put(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		put(OP_UPDATE, 1023, 7, 255, 1023, -1, 15, 65535, 65535, 65535);
		put(OP_UPDATE, 0, 0, 0, 0, 0, 0, 16'h6000, 16'h8000, 16'h1234);
		put(OP_UPDATE, 0, 0, 0, 0, 0, 0, 16'hAAAB, 0, 0);
		put(OP_SPARE_LO, 5, 2, 44, 6, 1234, 3, 7, 8, 9);
		put(OP_SPARE_MID, 1023, 7, 255, 1023, -32768, 15, 65535, 65535, 65535);
		put(OP_SPARE_HI, 0, 0, 0, 0, 32767, 0, 0, 0, 0);
		put(OP_RD_SPIN, 1, 0, 0, 0, 0, 0, 0, 0, 0);

		// every spin gets a value before wide node counts are used
		for (int n = 0; n < MAX_NODES; n++)
			put(OP_WR_SPIN, n, $urandom, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			set_config(phase_nc[p], phase_qc[p], phase_it[p], phase_zt[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				no_idle = (i < CALM_ITEMS);
				transfer_item(random_op_item());
			end
			no_idle = 1'b0;
			drain();
		end

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

FILE: filelist.f
rtl/core/pmu_pkg.sv
rtl/core/pmu_regs.sv
rtl/core/pmu_ctrl.sv
rtl/core/pmu_dp.sv
rtl/core/potts_metropolis_update_top.sv
verif/potts_metropolis_update_checker.sv
verif/potts_metropolis_update_top_tb.sv
